// ===== rtl/twa_pkg.sv =====
package twa_pkg;

    localparam int DEF_WINDOW_POINTS = 60;
    localparam int DEF_SAMPLE_BITS   = 32;

    localparam int CFG_INDEX_BITS   = 2;
    localparam int POINT_INDEX_BITS = 6;
    localparam int POINT_LEVEL_BITS = 7;
    localparam int OUT_TDATA_BITS   = 16;

    localparam int ONE_Q16     = 65536;
    localparam int PAD_DIVISOR = 10;
    localparam int LEVEL_FULL  = 100;
    localparam int LEVEL_SCALE = 2 * LEVEL_FULL;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOUNDS_GIVEN = 2'd0,
        REG_BOUND_LOW    = 2'd1,
        REG_BOUND_HIGH   = 2'd2
    } cfg_reg_t;

endpackage

// ===== rtl/trend_window_autoscaler_core.sv =====
// Gives WINDOW_POINTS results per input transaction. The min/max scan and the
// padding are skipped with a configured range. Each point is read, differenced and
// clamped, and goes through the divider only when its level lies strictly inside
// the span; output stalls hold it. No new transaction is taken until the last point
// is accepted. The one shared shift-subtract divider makes one quotient bit a cycle.
// Reset (aresetn, synchronous, active low) clears sequencer, valid marks and config.
module trend_window_autoscaler_core #(
    parameter int WINDOW_POINTS = twa_pkg::DEF_WINDOW_POINTS,
    parameter int SAMPLE_BITS   = twa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [SAMPLE_BITS-1:0] sample_value, zero fill to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // [0] sample_ok
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [5:0] point_index, [12:6] point_level, [13] point_present, [15:14] zero
    output logic [twa_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [twa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [SAMPLE_BITS-1:0]                cfg_data
);
    import twa_pkg::*;

    localparam int IW = $clog2(WINDOW_POINTS);
    localparam int WW = SAMPLE_BITS + 3;
    localparam int DW = SAMPLE_BITS + 10;
    localparam int VW = SAMPLE_BITS + 3;
    localparam int CW = $clog2(DW);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SCAN      = 13'b0000000000010,
        S_SCAN_TAIL = 13'b0000000000100,
        S_PAD_SEL   = 13'b0000000001000,
        S_DIV       = 13'b0000000010000,
        S_PAD_APPLY = 13'b0000000100000,
        S_SPAN      = 13'b0000001000000,
        S_P_READ    = 13'b0000010000000,
        S_P_DIFF    = 13'b0000100000000,
        S_P_CLAMP   = 13'b0001000000000,
        S_P_SUM     = 13'b0010000000000,
        S_P_LEVEL   = 13'b0100000000000,
        S_OUT       = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] window_mem [WINDOW_POINTS];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic mem_we;

    logic [WINDOW_POINTS-1:0] marks_reg, marks_next;
    logic [IW-1:0] wptr_reg, wptr_next;
    logic [IW-1:0] rptr_reg, rptr_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic bg_reg, bg_next;
    logic signed [SAMPLE_BITS-1:0] bl_reg, bl_next;
    logic signed [SAMPLE_BITS-1:0] bh_reg, bh_next;

    logic signed [WW-1:0] lo_reg, lo_next;
    logic signed [WW-1:0] hi_reg, hi_next;
    logic signed [WW-1:0] span_reg, span_next;
    logic signed [WW-1:0] d_reg, d_next;
    logic have_reg, have_next;
    logic flat_reg, flat_next;
    logic take_reg, take_next;
    logic mark_cur_reg, mark_cur_next;

    logic [DW-1:0] prod_reg, prod_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] divisor_reg, divisor_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic pad_op_reg, pad_op_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [POINT_INDEX_BITS-1:0] out_index_reg, out_index_next;
    logic [POINT_LEVEL_BITS-1:0] out_level_reg, out_level_next;
    logic out_present_reg, out_present_next;
    logic out_last_reg, out_last_next;

    logic signed [WW-1:0] sv;
    logic signed [WW-1:0] fold_lo, fold_hi;
    logic signed [WW-1:0] lo_mag;
    logic [WW-1:0] pad_q;
    logic [VW:0] div_trial;
    logic div_ge;
    logic [VW:0] div_rem;
    logic last_idx;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        if (p == IW'(WINDOW_POINTS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {2'b00, out_present_reg, out_level_reg, out_index_reg};

    assign sv       = {{(WW-SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
    assign fold_lo  = (!have_reg || sv < lo_reg) ? sv : lo_reg;
    assign fold_hi  = (!have_reg || sv > hi_reg) ? sv : hi_reg;
    assign lo_mag   = lo_reg[WW-1] ? -lo_reg : lo_reg;
    assign pad_q    = quo_reg[WW-1:0];
    assign last_idx = (idx_reg == IW'(WINDOW_POINTS - 1));

    assign div_trial = {rem_reg, quo_reg[DW-1]};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});
    assign div_rem   = div_ge ? (div_trial - {1'b0, divisor_reg}) : div_trial;

    always_comb begin
        state_next       = state_reg;
        marks_next       = marks_reg;
        wptr_next        = wptr_reg;
        rptr_next        = rptr_reg;
        idx_next         = idx_reg;
        bg_next          = bg_reg;
        bl_next          = bl_reg;
        bh_next          = bh_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        span_next        = span_reg;
        d_next           = d_reg;
        have_next        = have_reg;
        flat_next        = flat_reg;
        take_next        = take_reg;
        mark_cur_next    = mark_cur_reg;
        prod_next        = prod_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        cnt_next         = cnt_reg;
        pad_op_next      = pad_op_reg;
        m_tvalid_next    = m_tvalid_reg;
        out_index_next   = out_index_reg;
        out_level_next   = out_level_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOUNDS_GIVEN: bg_next = cfg_data[0];
                REG_BOUND_LOW:    bl_next = cfg_data;
                REG_BOUND_HIGH:   bh_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mem_we     = 1'b1;
                    marks_next = {s_tuser, marks_reg[WINDOW_POINTS-1:1]};
                    wptr_next  = ptr_inc(wptr_reg);
                    rptr_next  = ptr_inc(wptr_reg);
                    idx_next   = '0;
                    take_next  = 1'b0;
                    if (bg_reg && (bh_reg > bl_reg)) begin
                        lo_next    = {{(WW-SAMPLE_BITS){bl_reg[SAMPLE_BITS-1]}}, bl_reg};
                        hi_next    = {{(WW-SAMPLE_BITS){bh_reg[SAMPLE_BITS-1]}}, bh_reg};
                        have_next  = 1'b1;
                        state_next = S_PAD_SEL;
                    end else begin
                        have_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (take_reg) begin
                    lo_next   = fold_lo;
                    hi_next   = fold_hi;
                    have_next = 1'b1;
                end
                take_next = marks_reg[idx_reg];
                rptr_next = ptr_inc(rptr_reg);
                idx_next  = idx_reg + 1'b1;
                if (last_idx) begin
                    state_next = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL: begin
                if (take_reg) begin
                    lo_next   = fold_lo;
                    hi_next   = fold_hi;
                    have_next = 1'b1;
                end
                state_next = S_PAD_SEL;
            end
            S_PAD_SEL: begin
                rem_next     = '0;
                divisor_next = VW'(PAD_DIVISOR);
                cnt_next     = '0;
                pad_op_next  = 1'b1;
                if (!have_reg) begin
                    state_next = S_SPAN;
                end else if (hi_reg <= lo_reg) begin
                    flat_next  = 1'b1;
                    quo_next   = DW'(unsigned'(lo_mag));
                    state_next = S_DIV;
                end else if (!bg_reg) begin
                    flat_next  = 1'b0;
                    quo_next   = DW'(unsigned'(hi_reg - lo_reg));
                    state_next = S_DIV;
                end else begin
                    state_next = S_SPAN;
                end
            end
            S_DIV: begin
                rem_next = div_rem[VW-1:0];
                quo_next = {quo_reg[DW-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    state_next = pad_op_reg ? S_PAD_APPLY : S_P_LEVEL;
                end
            end
            S_PAD_APPLY: begin
                if (flat_reg && (pad_q < WW'(ONE_Q16))) begin
                    lo_next = lo_reg - WW'(ONE_Q16);
                    hi_next = hi_reg + WW'(ONE_Q16);
                end else begin
                    lo_next = lo_reg - signed'(pad_q);
                    hi_next = hi_reg + signed'(pad_q);
                end
                state_next = S_SPAN;
            end
            S_SPAN: begin
                span_next  = hi_reg - lo_reg;
                idx_next   = '0;
                rptr_next  = wptr_reg;
                state_next = S_P_READ;
            end
            S_P_READ: begin
                mark_cur_next  = marks_reg[idx_reg];
                out_index_next = POINT_INDEX_BITS'(idx_reg);
                out_last_next  = last_idx;
                state_next     = S_P_DIFF;
            end
            S_P_DIFF: begin
                d_next     = sv - lo_reg;
                state_next = S_P_CLAMP;
            end
            S_P_CLAMP: begin
                if (!have_reg || !mark_cur_reg) begin
                    out_level_next   = '0;
                    out_present_next = 1'b0;
                    m_tvalid_next    = 1'b1;
                    state_next       = S_OUT;
                end else if (d_reg <= 0) begin
                    out_level_next   = '0;
                    out_present_next = 1'b1;
                    m_tvalid_next    = 1'b1;
                    state_next       = S_OUT;
                end else if (d_reg >= span_reg) begin
                    out_level_next   = POINT_LEVEL_BITS'(LEVEL_FULL);
                    out_present_next = 1'b1;
                    m_tvalid_next    = 1'b1;
                    state_next       = S_OUT;
                end else begin
                    prod_next  = DW'(d_reg[SAMPLE_BITS+1:0]) * DW'(LEVEL_SCALE);
                    state_next = S_P_SUM;
                end
            end
            S_P_SUM: begin
                quo_next     = prod_reg + DW'(span_reg[SAMPLE_BITS+1:0]);
                rem_next     = '0;
                divisor_next = {span_reg[SAMPLE_BITS+1:0], 1'b0};
                cnt_next     = '0;
                pad_op_next  = 1'b0;
                state_next   = S_DIV;
            end
            S_P_LEVEL: begin
                out_level_next   = quo_reg[POINT_LEVEL_BITS-1:0];
                out_present_next = 1'b1;
                m_tvalid_next    = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        rptr_next  = ptr_inc(rptr_reg);
                        state_next = S_P_READ;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            window_mem[wptr_reg] <= s_tdata[SAMPLE_BITS-1:0];
        end
        rd_data_reg <= window_mem[rptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            marks_reg    <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            idx_reg      <= '0;
            bg_reg       <= 1'b0;
            bl_reg       <= '0;
            bh_reg       <= '0;
            have_reg     <= 1'b0;
            flat_reg     <= 1'b0;
            take_reg     <= 1'b0;
            pad_op_reg   <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            marks_reg    <= marks_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            idx_reg      <= idx_next;
            bg_reg       <= bg_next;
            bl_reg       <= bl_next;
            bh_reg       <= bh_next;
            have_reg     <= have_next;
            flat_reg     <= flat_next;
            take_reg     <= take_next;
            pad_op_reg   <= pad_op_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        span_reg        <= span_next;
        d_reg           <= d_next;
        mark_cur_reg    <= mark_cur_next;
        prod_reg        <= prod_next;
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        divisor_reg     <= divisor_next;
        out_index_reg   <= out_index_next;
        out_level_reg   <= out_level_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("sequencer not idle after final point");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer did not start after accepted transaction");

    a_gap_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_present_reg) |-> (out_level_reg == '0))
        else $error("absent point carries a nonzero level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_level_reg <= POINT_LEVEL_BITS'(LEVEL_FULL)))
        else $error("point level above full scale");

endmodule

// ===== dv/tb_trend_window_autoscaler_core.sv =====
`timescale 1ns / 1ps

module tb_trend_window_autoscaler_core;
    import twa_pkg::*;

    localparam int          WIN          = DEF_WINDOW_POINTS;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam int          HOLD_AT      = 20 * WIN;
    localparam int          HOLD_CYCLES  = 12_000;
    localparam int          BURST_LO     = 3000;
    localparam int          BURST_HI     = 4800;
    localparam int          DRAIN_CYCLES = 3200;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_ALL_ABSENT, EXP_NEWEST} row_exp_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] data;
        logic        ok;
        row_exp_t    exp_mode;
        logic [6:0]  lvl;
    } dir_row_t;

    typedef struct packed {
        logic [5:0] idx;
        logic [6:0] level;
        logic       present;
        logic       last;
    } point_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    point_t             expected_points[$];
    dir_row_t           dir_rows[$];
    logic signed [31:0] win_val [WIN];
    logic               win_mark[WIN];
    logic               bounds_on  = 1'b0;
    longint             bound_lo_q = 0;
    longint             bound_hi_q = 0;
    int                 mismatches = 0;
    int                 points_seen = 0;
    int                 feed_idle_pct = 27;
    longint             cycle_count = 0;

    always #2 aclk = ~aclk;

    trend_window_autoscaler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic dir_row_t sample_row(input logic [31:0] v, input logic ok,
                                            input row_exp_t mode, input int lvl);
        dir_row_t r;
        r.kind     = ROW_SAMPLE;
        r.reg_idx  = '0;
        r.data     = v;
        r.ok       = ok;
        r.exp_mode = mode;
        r.lvl      = 7'(lvl);
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [31:0] v);
        dir_row_t r;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.data     = v;
        r.ok       = 1'b0;
        r.exp_mode = EXP_MODEL;
        r.lvl      = '0;
        return r;
    endfunction

    // shift the window, pick the scale and queue one point per slot
    function automatic void predict_tick(input logic [31:0] raw, input logic ok,
                                         input row_exp_t mode, input int typed_lvl);
        longint lo, hi, span, pad, num, v, level;
        logic   have, present;
        point_t pt;
        for (int i = 0; i < WIN - 1; i++) begin
            win_val[i]  = win_val[i+1];
            win_mark[i] = win_mark[i+1];
        end
        win_val[WIN-1]  = ok ? raw : '0;
        win_mark[WIN-1] = ok;

        have = 1'b0;
        lo   = 0;
        hi   = 0;
        if (bounds_on && bound_hi_q > bound_lo_q) begin
            lo   = bound_lo_q;
            hi   = bound_hi_q;
            have = 1'b1;
        end else begin
            for (int i = 0; i < WIN; i++) begin
                if (win_mark[i]) begin
                    v = longint'(win_val[i]);
                    if (!have) begin
                        lo   = v;
                        hi   = v;
                        have = 1'b1;
                    end else begin
                        if (v < lo) lo = v;
                        if (v > hi) hi = v;
                    end
                end
            end
        end

        if (have) begin
            if (hi <= lo) begin
                pad = (lo < 0 ? -lo : lo) / PAD_DIVISOR;
                if (pad < ONE_Q16) pad = ONE_Q16;
                lo -= pad;
                hi += pad;
            end else if (!bounds_on) begin
                pad = (hi - lo) / PAD_DIVISOR;
                lo -= pad;
                hi += pad;
            end
        end
        span = hi - lo;

        for (int i = 0; i < WIN; i++) begin
            level   = 0;
            present = 1'b0;
            if (have && win_mark[i] && span > 0) begin
                num     = (longint'(win_val[i]) - lo) * LEVEL_FULL;
                present = 1'b1;
                if (num <= 0)
                    level = 0;
                else if (num >= span * LEVEL_FULL)
                    level = LEVEL_FULL;
                else
                    level = (2 * num + span) / (2 * span);
            end
            if (mode == EXP_ALL_ABSENT) begin
                level   = 0;
                present = 1'b0;
            end else if (mode == EXP_NEWEST && i == WIN - 1) begin
                level   = typed_lvl;
                present = 1'b1;
            end
            pt.idx     = 6'(i);
            pt.level   = 7'(level);
            pt.present = present;
            pt.last    = (i == WIN - 1);
            expected_points.push_back(pt);
        end
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BOUNDS_GIVEN: bounds_on  = val[0];
            REG_BOUND_LOW:    bound_lo_q = longint'($signed(val));
            REG_BOUND_HIGH:   bound_hi_q = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic feed_sample(input logic [31:0] v, input logic ok,
                               input row_exp_t mode, input int typed_lvl);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= v;
        s_tuser  <= ok;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tick(v, ok, mode, typed_lvl);
    endtask

    task automatic check_point(input point_t got);
        point_t want;
        if (expected_points.size() == 0) begin
            $error("unexpected point: point_index %0d", got.idx);
            mismatches++;
        end else begin
            want = expected_points.pop_front();
            if (got.idx !== want.idx) begin
                $error("point_index: expected %0d, got %0d", want.idx, got.idx);
                mismatches++;
            end
            if (got.level !== want.level) begin
                $error("point_level: expected %0d, got %0d", want.level, got.level);
                mismatches++;
            end
            if (got.present !== want.present) begin
                $error("point_present: expected %0d, got %0d", want.present, got.present);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("run_last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
        points_seen++;
    endtask

    initial begin : result_sink
        int  hold_left;
        bit  held;
        int  idle_pct;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_point({m_tdata[5:0], m_tdata[12:6], m_tdata[13], m_tlast});
            idle_pct = (points_seen >= BURST_LO && points_seen < BURST_HI) ? 0 : 27;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && points_seen == HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          base, amp, band, pick, len;
        logic [31:0] v, lo_w, hi_w, flat_val;
        logic        ok, g;

        for (int i = 0; i < WIN; i++) begin
            win_val[i]  = '0;
            win_mark[i] = 1'b0;
        end

        dir_rows.push_back(sample_row(32'h1234_5678, 1'b0, EXP_ALL_ABSENT, 0));
        dir_rows.push_back(sample_row(32'hFED4_0000, 1'b1, EXP_NEWEST, 50));
        dir_rows.push_back(sample_row(32'h7FFF_FFFF, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(sample_row(32'h8000_0000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(sample_row(32'hFFFF_FFFF, 1'b0, EXP_MODEL, 0));
        dir_rows.push_back(sample_row(32'h0000_8000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(reg_row(REG_BOUND_LOW, 32'h0000_0000));
        dir_rows.push_back(reg_row(REG_BOUND_HIGH, 32'h0064_0000));
        dir_rows.push_back(reg_row(REG_BOUNDS_GIVEN, 32'h0000_0001));
        dir_rows.push_back(sample_row(32'h0032_0000, 1'b1, EXP_NEWEST, 50));
        dir_rows.push_back(sample_row(32'h0000_8000, 1'b1, EXP_NEWEST, 1));
        dir_rows.push_back(sample_row(32'h0063_8000, 1'b1, EXP_NEWEST, 100));
        dir_rows.push_back(sample_row(32'hFFFD_0000, 1'b1, EXP_NEWEST, 0));
        dir_rows.push_back(sample_row(32'h7FFF_FFFF, 1'b1, EXP_NEWEST, 100));
        dir_rows.push_back(sample_row(32'h8000_0000, 1'b1, EXP_NEWEST, 0));
        dir_rows.push_back(sample_row(32'h0021_4CCC, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(reg_row(REG_BOUND_LOW, 32'h8000_0000));
        dir_rows.push_back(reg_row(REG_BOUND_HIGH, 32'h7FFF_FFFF));
        dir_rows.push_back(sample_row(32'h0000_0000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(sample_row(32'h7FFF_FFFF, 1'b1, EXP_NEWEST, 100));
        dir_rows.push_back(reg_row(REG_BOUND_HIGH, 32'h8000_0000));
        dir_rows.push_back(sample_row(32'h0010_0000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(reg_row(REG_BOUND_LOW, 32'h8000_0000));
        dir_rows.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
        dir_rows.push_back(sample_row(32'hFFF0_0000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(reg_row(REG_BOUNDS_GIVEN, 32'h0000_0000));
        dir_rows.push_back(sample_row(32'h0005_0000, 1'b1, EXP_MODEL, 0));
        dir_rows.push_back(sample_row(32'h0005_0000, 1'b0, EXP_MODEL, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG)
                write_reg(dir_rows[r].reg_idx, dir_rows[r].data);
            else
                feed_sample(dir_rows[r].data, dir_rows[r].ok, dir_rows[r].exp_mode,
                            int'(dir_rows[r].lvl));
        end

        for (int ph = 0; ph < 6; ph++) begin
            base = int'($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
            amp  = int'($urandom_range(65536, 50 * 65536));
            band = int'($urandom_range(65536, 60 * 65536));
            case (ph)
                0: begin
                    g = 1'b0; lo_w = $urandom; hi_w = $urandom;
                end
                1: begin
                    g = 1'b1; lo_w = base - band; hi_w = base + band;
                end
                2: begin
                    g = 1'b1; lo_w = base + band; hi_w = base - band;
                end
                3: begin
                    g = 1'($urandom_range(1)); lo_w = $urandom; hi_w = lo_w;
                end
                4: begin
                    g = 1'b1; lo_w = 32'h8000_0000; hi_w = 32'h7FFF_FFFF;
                end
                default: begin
                    g = 1'($urandom_range(1)); lo_w = $urandom; hi_w = $urandom;
                end
            endcase
            write_reg(REG_BOUNDS_GIVEN, {31'b0, g});
            write_reg(REG_BOUND_LOW, lo_w);
            write_reg(REG_BOUND_HIGH, hi_w);
            if (ph == 5)
                write_reg(REG_UNUSED, $urandom);

            feed_idle_pct = (ph == 2) ? 0 : 27;
            flat_val      = $urandom;
            len           = (ph == 3) ? WIN : 16;
            for (int n = 0; n < len; n++) begin
                if (ph == 3) begin
                    v  = flat_val;
                    ok = 1'($urandom_range(1));
                end else begin
                    pick = int'($urandom_range(99));
                    ok   = (pick >= 12);
                    if (pick < 20)
                        v = $urandom;
                    else if (pick < 25)
                        v = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
                    else
                        v = base + int'($urandom_range(0, 2 * amp)) - amp;
                end
                feed_sample(v, ok, EXP_MODEL, 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
